/* src/sdsw_pkg.sv */
// Shared types, codes and the segment table for the serial display writer.
`default_nettype none
package sdsw_pkg;

   localparam int CharInputs = 6;

   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_BRIGHT = 3'd1;
   localparam logic [2:0] CMD_SWITCH = 3'd2;
   localparam logic [2:0] CMD_MODE   = 3'd3;
   localparam logic [2:0] CMD_PRINT  = 3'd4;
   localparam logic [2:0] CMD_ADDR   = 3'd5;

   localparam logic [7:0] BYTE_MODE_BASE = 8'h40;
   localparam logic [7:0] BYTE_CTRL_BASE = 8'h80;
   localparam logic [7:0] BYTE_ADDR_BASE = 8'hC0;
   localparam logic [7:0] BYTE_DISP_ON   = 8'h08;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_BRIGHT,
      KIND_SWITCH,
      KIND_MODE,
      KIND_PRINT,
      KIND_ADDR
   } kind_type;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_START_B,
      PH_START_C,
      PH_CLK_HI,
      PH_CLK_LO,
      PH_BIT_NEXT,
      PH_ACK_SAMPLE,
      PH_ACK_CLK_LO,
      PH_ACK_PAD,
      PH_ACK_END,
      PH_STOP_B,
      PH_STOP_C,
      PH_FINISH
   } phase_type;

   // One classified request as it sits in the queue.
   typedef struct packed {
      kind_type                        kind;
      logic [7:0]                      arg;
      logic [CharInputs-1:0][7:0]      seg;
      logic                            dio_sample;
   } item_type;

   typedef struct packed {
      logic clk_level;
      logic dio_level;
      logic dio_drive;
      logic busy_res;
      logic ack_error;
      logic transfer_done;
   } rsp_type;

   function automatic logic [7:0] seg_code(input logic [7:0] ch);
      logic [7:0] c;
      logic [7:0] code;
      c = ch;
      if (ch >= 8'h61 && ch <= 8'h7A) begin
         c = ch - 8'd32;
      end
      case (c)
         8'h30:        code = 8'h3F; // 0
         8'h31, 8'h49: code = 8'h06; // 1 I
         8'h32:        code = 8'h5B;
         8'h33:        code = 8'h4F;
         8'h34:        code = 8'h66;
         8'h35, 8'h53: code = 8'h6D; // 5 S
         8'h36:        code = 8'h7D;
         8'h37:        code = 8'h07;
         8'h38:        code = 8'h7F;
         8'h39:        code = 8'h6F;
         8'h41:        code = 8'h77; // A
         8'h42:        code = 8'h7C;
         8'h43:        code = 8'h39;
         8'h44:        code = 8'h5E;
         8'h45:        code = 8'h79;
         8'h46:        code = 8'h71;
         8'h2D:        code = 8'h40; // minus
         8'h5F:        code = 8'h08; // underscore
         8'h48:        code = 8'h76; // H
         8'h4A:        code = 8'h1E;
         8'h4C:        code = 8'h38;
         8'h4F:        code = 8'h5C; // O, lower ring
         8'h50:        code = 8'h73;
         8'h54:        code = 8'h78;
         8'h55:        code = 8'h3E;
         8'h56:        code = 8'h1C;
         8'h59:        code = 8'h6E;
         default:      code = 8'h00;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

/* src/sdsw_front.sv */
// Front end: classifies a request and encodes its characters.
`default_nettype none
module sdsw_front import sdsw_pkg::*; #(
   parameter int DIGIT_SLOTS = 6
) (
   input  wire logic [2:0] command,
   input  wire logic [7:0] value,
   input  wire logic [7:0] char_slot0,
   input  wire logic [7:0] char_slot1,
   input  wire logic [7:0] char_slot2,
   input  wire logic [7:0] char_slot3,
   input  wire logic [7:0] char_slot4,
   input  wire logic [7:0] char_slot5,
   input  wire logic       dio_sample,
   output item_type        item
);

   localparam logic [7:0] AddrMax = 8'(DIGIT_SLOTS - 1);

   always_comb begin
      item.dio_sample = dio_sample;
      item.seg[0] = seg_code(char_slot0);
      item.seg[1] = seg_code(char_slot1);
      item.seg[2] = seg_code(char_slot2);
      item.seg[3] = seg_code(char_slot3);
      item.seg[4] = seg_code(char_slot4);
      item.seg[5] = seg_code(char_slot5);
      item.arg  = value;
      case (command)
         CMD_TICK: begin
            item.kind = KIND_NONE;
         end
         CMD_BRIGHT: begin
            item.kind = KIND_BRIGHT;
            item.arg  = (value > 8'd7) ? 8'd7 : value;
         end
         CMD_SWITCH: begin
            item.kind = KIND_SWITCH;
            item.arg  = {7'd0, value != 8'd0};
         end
         CMD_MODE: begin
            item.kind = KIND_MODE;
            item.arg  = {4'd0, value[3:0]};
         end
         CMD_PRINT: begin
            item.kind = KIND_PRINT;
         end
         CMD_ADDR: begin
            item.kind = KIND_ADDR;
            item.arg  = (value > AddrMax) ? AddrMax : value;
         end
         default: begin
            item.kind = KIND_NONE;
         end
      endcase
   end

endmodule
`default_nettype wire

/* src/sdsw_queue.sv */
// Two-entry queue of classified requests between front and back.
`default_nettype none
module sdsw_queue import sdsw_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          full,
   input  wire logic     pop,
   output logic          not_empty,
   output item_type      head
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

/* src/sdsw_back.sv */
// Back end: tick sequencer for the two-wire bus and the response register.
`default_nettype none
module sdsw_back import sdsw_pkg::*; #(
   parameter int DIGIT_SLOTS     = 6,
   parameter int BIT_HOLD_TICKS  = 5,
   parameter int EDGE_HOLD_TICKS = 2
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       item_valid,
   input  wire item_type   item,
   output logic            item_pop,
   input  wire logic       csr_wr_en,
   input  wire logic [2:0] csr_wr_data,
   input  wire logic       rsp_ready,
   output logic            rsp_valid,
   output rsp_type         rsp
);

   localparam int FrameDepth = DIGIT_SLOTS + 1;
   localparam int LenW       = $clog2(FrameDepth + 1);
   localparam int AddrW      = $clog2(FrameDepth);
   localparam logic [3:0] SlotCount = 4'(DIGIT_SLOTS);
   localparam logic [2:0] BitHold   = 3'(BIT_HOLD_TICKS - 1);
   localparam logic [2:0] EdgeHold  = 3'(EDGE_HOLD_TICKS - 1);
   localparam logic [LenW-1:0] DepthLen = LenW'(FrameDepth);

   phase_type       phase_ff, phase_in;
   logic [2:0]      hold_ff, hold_in;
   logic [2:0]      bit_idx_ff, bit_idx_in;
   logic [LenW-1:0] byte_idx_ff, byte_idx_in;
   logic [LenW-1:0] frame_len_ff, frame_len_in;
   logic [7:0]      shift_ff, shift_in;
   logic [7:0]      frame_ff [FrameDepth];
   logic [7:0]      frame_in [FrameDepth];
   logic [2:0]      bright_ff, bright_in;
   logic            ack_fail_ff, ack_fail_in;
   logic            clk_ff, clk_in;
   logic            dio_ff, dio_in;
   logic            oe_ff, oe_in;
   logic [2:0]      digits_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_ff, rsp_in;

   logic [3:0]      shown;
   logic [LenW-1:0] next_idx;
   logic [7:0]      next_byte;
   logic            done;
   int              pos;

   assign item_pop  = item_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign shown     = ({1'b0, digits_ff} > SlotCount) ? SlotCount : {1'b0, digits_ff};
   assign next_idx  = byte_idx_ff + LenW'(1);
   assign next_byte = frame_ff[next_idx[AddrW-1:0]];

   always_comb begin
      phase_in     = phase_ff;
      hold_in      = hold_ff;
      bit_idx_in   = bit_idx_ff;
      byte_idx_in  = byte_idx_ff;
      frame_len_in = frame_len_ff;
      shift_in     = shift_ff;
      frame_in     = frame_ff;
      bright_in    = bright_ff;
      ack_fail_in  = ack_fail_ff;
      clk_in       = clk_ff;
      dio_in       = dio_ff;
      oe_in        = oe_ff;
      done         = 1'b0;
      pos          = 0;

      if (phase_ff != PH_IDLE && hold_ff != 3'd0) begin
         hold_in = hold_ff - 3'd1;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               if (item.kind != KIND_NONE) begin
                  frame_len_in = LenW'(1);
                  case (item.kind)
                     KIND_BRIGHT: begin
                        bright_in   = item.arg[2:0];
                        frame_in[0] = BYTE_CTRL_BASE | BYTE_DISP_ON | {5'd0, item.arg[2:0]};
                     end
                     KIND_SWITCH: begin
                        frame_in[0] = BYTE_CTRL_BASE | (item.arg[0] ? BYTE_DISP_ON : 8'h00)
                                      | {5'd0, bright_ff};
                     end
                     KIND_MODE: begin
                        frame_in[0] = BYTE_MODE_BASE | item.arg;
                     end
                     KIND_PRINT: begin
                        frame_in[0]  = BYTE_ADDR_BASE;
                        frame_len_in = LenW'(shown) + LenW'(1);
                        for (int i = 0; i < DIGIT_SLOTS; i++) begin
                           pos = CharInputs - int'(shown) + i;
                           if (pos >= 0 && pos < CharInputs) begin
                              frame_in[i+1] = item.seg[pos[2:0]];
                           end else begin
                              frame_in[i+1] = 8'h00;
                           end
                        end
                     end
                     default: begin
                        frame_in[0] = BYTE_ADDR_BASE | item.arg;
                     end
                  endcase
                  ack_fail_in = 1'b0;
                  byte_idx_in = '0;
                  oe_in       = 1'b1;
                  dio_in      = 1'b1;
                  clk_in      = 1'b1;
                  phase_in    = PH_START_B;
                  hold_in     = EdgeHold;
               end
            end
            PH_START_B: begin
               dio_in   = 1'b0;
               phase_in = PH_START_C;
               hold_in  = EdgeHold;
            end
            PH_START_C: begin
               clk_in      = 1'b0;
               byte_idx_in = '0;
               shift_in    = frame_ff[0];
               bit_idx_in  = 3'd0;
               oe_in       = 1'b1;
               dio_in      = frame_ff[0][0];
               phase_in    = PH_CLK_HI;
               hold_in     = BitHold;
            end
            PH_CLK_HI: begin
               clk_in   = 1'b1;
               phase_in = PH_CLK_LO;
               hold_in  = BitHold;
            end
            PH_CLK_LO: begin
               clk_in   = 1'b0;
               phase_in = PH_BIT_NEXT;
               hold_in  = BitHold;
            end
            PH_BIT_NEXT: begin
               if (bit_idx_ff != 3'd7) begin
                  bit_idx_in = bit_idx_ff + 3'd1;
                  shift_in   = {1'b0, shift_ff[7:1]};
                  dio_in     = shift_ff[1];
                  phase_in   = PH_CLK_HI;
               end else begin
                  oe_in    = 1'b0;
                  phase_in = PH_ACK_SAMPLE;
               end
               hold_in = BitHold;
            end
            PH_ACK_SAMPLE: begin
               if (item.dio_sample) begin
                  ack_fail_in = 1'b1;
               end
               clk_in   = 1'b1;
               phase_in = PH_ACK_CLK_LO;
               hold_in  = BitHold;
            end
            PH_ACK_CLK_LO: begin
               clk_in   = 1'b0;
               phase_in = PH_ACK_PAD;
               hold_in  = BitHold;
            end
            PH_ACK_PAD: begin
               phase_in = PH_ACK_END;
               hold_in  = BitHold;
            end
            PH_ACK_END: begin
               if (!item.dio_sample) begin
                  ack_fail_in = 1'b1;
               end
               oe_in       = 1'b1;
               byte_idx_in = next_idx;
               if (next_idx < frame_len_ff && next_idx < DepthLen) begin
                  shift_in   = next_byte;
                  bit_idx_in = 3'd0;
                  dio_in     = next_byte[0];
                  phase_in   = PH_CLK_HI;
                  hold_in    = BitHold;
               end else begin
                  clk_in   = 1'b0;
                  dio_in   = 1'b0;
                  phase_in = PH_STOP_B;
                  hold_in  = EdgeHold;
               end
            end
            PH_STOP_B: begin
               clk_in   = 1'b1;
               phase_in = PH_STOP_C;
               hold_in  = EdgeHold;
            end
            PH_STOP_C: begin
               dio_in   = 1'b1;
               phase_in = PH_FINISH;
               hold_in  = EdgeHold;
            end
            default: begin
               phase_in = PH_IDLE;
               hold_in  = 3'd0;
               done     = 1'b1;
            end
         endcase
      end

      rsp_in.clk_level     = clk_in;
      rsp_in.dio_level     = dio_in;
      rsp_in.dio_drive     = oe_in;
      rsp_in.busy_res      = phase_in != PH_IDLE;
      rsp_in.ack_error     = (phase_in == PH_IDLE) ? ack_fail_in : 1'b0;
      rsp_in.transfer_done = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         hold_ff      <= 3'd0;
         bit_idx_ff   <= 3'd0;
         byte_idx_ff  <= '0;
         frame_len_ff <= '0;
         shift_ff     <= 8'd0;
         bright_ff    <= 3'd0;
         ack_fail_ff  <= 1'b0;
         clk_ff       <= 1'b0;
         dio_ff       <= 1'b0;
         oe_ff        <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (item_pop) begin
            phase_ff     <= phase_in;
            hold_ff      <= hold_in;
            bit_idx_ff   <= bit_idx_in;
            byte_idx_ff  <= byte_idx_in;
            frame_len_ff <= frame_len_in;
            shift_ff     <= shift_in;
            bright_ff    <= bright_in;
            ack_fail_ff  <= ack_fail_in;
            clk_ff       <= clk_in;
            dio_ff       <= dio_in;
            oe_ff        <= oe_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff <= 3'd6;
      end else if (csr_wr_en) begin
         digits_ff <= csr_wr_data;
      end
   end

   // Frame store and response payload carry no reset.
   always_ff @(posedge clock) begin
      if (item_pop) begin
         frame_ff <= frame_in;
         rsp_ff   <= rsp_in;
      end
   end

endmodule
`default_nettype wire

/* src/segment_display_serial_writer_top.sv */
// Top level of the two-wire seven-segment display writer.
// Usage:
//  - Each request on req_ is one microsecond tick of the bus waveform: a
//    command (0 is a plain tick), its value, six ASCII characters for print
//    and the level read back from the data line in that tick.
//  - Commands count only while the transmitter is idle; otherwise the request
//    just advances the waveform by one tick.
//  - Every request gives exactly one response on rsp_: the clock and data
//    line levels, data drive enable, busy, the acknowledge error flag of the
//    last finished transfer and a done pulse on the tick the stop completes.
//  - csr_wr_en with csr_wr_data sets how many rightmost characters a print
//    sends (reset value 6); write it only while idle.
// Timing:
//  - Each request is stored in the queue, then its response is registered.
//  - One request per cycle while responses are taken: the bus sequencer takes
//    one tick step per cycle, fed from a two-entry queue behind the decoder.
//  - If rsp_ready stays low the response register holds, the queue fills
//    and req_ready drops after two more requests.
//  - Synchronous reset returns to idle with clock low, data low and driven,
//    brightness 0 and an empty queue.
`default_nettype none
module segment_display_serial_writer_top import sdsw_pkg::*; #(
   parameter int DIGIT_SLOTS     = 6,
   parameter int BIT_HOLD_TICKS  = 5,
   parameter int EDGE_HOLD_TICKS = 2
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [2:0] req_command,
   input  wire logic [7:0] req_value,
   input  wire logic [7:0] req_char_slot0,
   input  wire logic [7:0] req_char_slot1,
   input  wire logic [7:0] req_char_slot2,
   input  wire logic [7:0] req_char_slot3,
   input  wire logic [7:0] req_char_slot4,
   input  wire logic [7:0] req_char_slot5,
   input  wire logic       req_dio_sample,
   // response channel
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_clk_level,
   output logic            rsp_dio_level,
   output logic            rsp_dio_drive,
   output logic            rsp_busy_res,
   output logic            rsp_ack_error,
   output logic            rsp_transfer_done,
   // configuration
   input  wire logic       csr_wr_en,
   input  wire logic [2:0] csr_wr_data
);

   item_type front_item;
   item_type head_item;
   logic     queue_full;
   logic     queue_not_empty;
   logic     queue_pop;
   rsp_type  back_rsp;

   // Decoder: command classification, clamping and segment encoding.
   sdsw_front #(
      .DIGIT_SLOTS (DIGIT_SLOTS)
   ) u_front (
      .command    (req_command),
      .value      (req_value),
      .char_slot0 (req_char_slot0),
      .char_slot1 (req_char_slot1),
      .char_slot2 (req_char_slot2),
      .char_slot3 (req_char_slot3),
      .char_slot4 (req_char_slot4),
      .char_slot5 (req_char_slot5),
      .dio_sample (req_dio_sample),
      .item       (front_item)
   );

   assign req_ready = !queue_full;

   // Decouples the request side from response stalls.
   sdsw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !queue_full),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .head      (head_item)
   );

   // Bus sequencer, one tick step per dequeued request.
   sdsw_back #(
      .DIGIT_SLOTS     (DIGIT_SLOTS),
      .BIT_HOLD_TICKS  (BIT_HOLD_TICKS),
      .EDGE_HOLD_TICKS (EDGE_HOLD_TICKS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (queue_not_empty),
      .item        (head_item),
      .item_pop    (queue_pop),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp         (back_rsp)
   );

   assign rsp_clk_level     = back_rsp.clk_level;
   assign rsp_dio_level     = back_rsp.dio_level;
   assign rsp_dio_drive     = back_rsp.dio_drive;
   assign rsp_busy_res      = back_rsp.busy_res;
   assign rsp_ack_error     = back_rsp.ack_error;
   assign rsp_transfer_done = back_rsp.transfer_done;

endmodule
`default_nettype wire

/* tb/segment_display_serial_writer_top_test.sv */
// Testbench for the segment display serial writer: tick-by-tick bus waveform check.
`default_nettype none
module segment_display_serial_writer_top_test import sdsw_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // Block parameters; the predictor uses the same values.
   localparam int DigitSlots = 6;
   localparam int BitHold    = 5;
   localparam int EdgeHold   = 2;
   localparam int FrameDepth = DigitSlots + 1;

   // Command codes the block treats as no-ops.
   localparam logic [2:0] CMD_SPARE6 = 3'd6;
   localparam logic [2:0] CMD_SPARE7 = 3'd7;

   // One tick request as driven on the req_ ports; chars[0] is the leftmost slot.
   typedef struct packed {
      logic [2:0]      command;
      logic [7:0]      value;
      logic [5:0][7:0] chars;
      logic            dio_sample;
   } request_type;

   // How the data line answers in the two acknowledge sample ticks.
   typedef enum {ACK_CLEAN, ACK_MISS_LOW, ACK_MISS_HIGH, ACK_RANDOM} ack_plan_type;
   typedef enum {SLOT_NONE, SLOT_FIRST, SLOT_SECOND} ack_slot_type;
   typedef enum {RX_OPEN, RX_PATTERN, RX_RANDOM} rx_mode_type;

   // Line-level predictor plus the queue of expected responses.
   class wave_scoreboard;
      phase_type   seq_phase;
      int unsigned hold_left;
      int unsigned bit_pos;
      int unsigned byte_pos;
      int unsigned frame_len;
      logic [7:0]  shift_reg;
      logic [7:0]  frame [FrameDepth];
      logic [2:0]  bright;
      logic [2:0]  digits_cfg;
      logic        ack_bad;
      logic        clk_q;
      logic        dio_q;
      logic        oe_q;
      rsp_type     expected_levels[$];
      int unsigned mismatches;
      int unsigned transfers;
      int unsigned done_seen;
      int unsigned ack_errors_seen;
      int unsigned responses;

      function new();
         seq_phase  = PH_IDLE;
         hold_left  = 0;
         bit_pos    = 0;
         byte_pos   = 0;
         frame_len  = 0;
         shift_reg  = '0;
         foreach (frame[i]) frame[i] = '0;
         bright     = '0;
         digits_cfg = 3'd6;
         ack_bad    = 1'b0;
         clk_q      = 1'b0;
         dio_q      = 1'b0;
         oe_q       = 1'b1;
         mismatches = 0;
         transfers  = 0;
         done_seen  = 0;
         ack_errors_seen = 0;
         responses  = 0;
      endfunction

      function void hop(phase_type nxt, int unsigned ticks);
         seq_phase = nxt;
         hold_left = (ticks - 1) & 7;
      endfunction

      function void load_frame_byte();
         shift_reg = frame[byte_pos];
         bit_pos   = 0;
         oe_q      = 1'b1;
         dio_q     = shift_reg[0];
         hop(PH_CLK_HI, BitHold);
      endfunction

      function logic [7:0] glyph(logic [7:0] ch);
         logic [7:0] c;
         c = ch;
         if (ch >= 8'h61 && ch <= 8'h7A) c = ch - 8'd32;   // fold lower case
         case (c)
            8'h30: return 8'h3F;
            8'h31: return 8'h06;
            8'h32: return 8'h5B;
            8'h33: return 8'h4F;
            8'h34: return 8'h66;
            8'h35: return 8'h6D;
            8'h36: return 8'h7D;
            8'h37: return 8'h07;
            8'h38: return 8'h7F;
            8'h39: return 8'h6F;
            8'h41: return 8'h77;
            8'h42: return 8'h7C;
            8'h43: return 8'h39;
            8'h44: return 8'h5E;
            8'h45: return 8'h79;
            8'h46: return 8'h71;
            8'h48: return 8'h76;
            8'h49: return 8'h06;   // I shares the 1 glyph
            8'h4A: return 8'h1E;
            8'h4C: return 8'h38;
            8'h4F: return 8'h5C;   // O drawn as the lower ring
            8'h50: return 8'h73;
            8'h53: return 8'h6D;   // S shares the 5 glyph
            8'h54: return 8'h78;
            8'h55: return 8'h3E;
            8'h56: return 8'h1C;
            8'h59: return 8'h6E;
            8'h2D: return 8'h40;
            8'h5F: return 8'h08;
            default: return 8'h00;
         endcase
      endfunction

      // Builds the frame for a command taken while idle; 0 if it is a no-op.
      function bit start_frame(request_type r);
         int unsigned n;
         case (r.command)
            CMD_BRIGHT: begin
               bright    = (r.value > 8'd7) ? 3'd7 : r.value[2:0];
               frame[0]  = BYTE_CTRL_BASE | BYTE_DISP_ON | {5'd0, bright};
               frame_len = 1;
            end
            CMD_SWITCH: begin
               frame[0]  = BYTE_CTRL_BASE | ((r.value != 8'd0) ? BYTE_DISP_ON : 8'h00)
                           | {5'd0, bright};
               frame_len = 1;
            end
            CMD_MODE: begin
               frame[0]  = BYTE_MODE_BASE | {4'd0, r.value[3:0]};
               frame_len = 1;
            end
            CMD_PRINT: begin
               n = (digits_cfg > DigitSlots) ? DigitSlots : digits_cfg;
               frame[0] = BYTE_ADDR_BASE;
               for (int i = 0; i < n; i++) frame[1 + i] = glyph(r.chars[DigitSlots - n + i]);
               frame_len = 1 + n;
            end
            CMD_ADDR: begin
               frame[0]  = BYTE_ADDR_BASE | ((r.value > 8'(DigitSlots - 1)) ?
                                             8'(DigitSlots - 1) : r.value);
               frame_len = 1;
            end
            default: return 1'b0;
         endcase
         ack_bad  = 1'b0;
         byte_pos = 0;
         oe_q     = 1'b1;
         dio_q    = 1'b1;
         clk_q    = 1'b1;
         hop(PH_START_B, EdgeHold);
         return 1'b1;
      endfunction

      // Advances the predictor by one accepted tick and queues its response.
      function void note_request(request_type r);
         rsp_type lv;
         logic    finished;
         finished = 1'b0;
         if (seq_phase != PH_IDLE && hold_left > 0) begin
            hold_left--;
         end else begin
            case (seq_phase)
               PH_IDLE: begin
                  if (start_frame(r)) transfers++;
               end
               PH_START_B: begin
                  dio_q = 1'b0;
                  hop(PH_START_C, EdgeHold);
               end
               PH_START_C: begin
                  clk_q    = 1'b0;
                  byte_pos = 0;
                  load_frame_byte();
               end
               PH_CLK_HI: begin
                  clk_q = 1'b1;
                  hop(PH_CLK_LO, BitHold);
               end
               PH_CLK_LO: begin
                  clk_q = 1'b0;
                  hop(PH_BIT_NEXT, BitHold);
               end
               PH_BIT_NEXT: begin
                  if (bit_pos < 7) begin
                     bit_pos++;
                     shift_reg = shift_reg >> 1;
                     dio_q     = shift_reg[0];
                     hop(PH_CLK_HI, BitHold);
                  end else begin
                     oe_q = 1'b0;   // release for acknowledge
                     hop(PH_ACK_SAMPLE, BitHold);
                  end
               end
               PH_ACK_SAMPLE: begin
                  if (r.dio_sample) ack_bad = 1'b1;
                  clk_q = 1'b1;
                  hop(PH_ACK_CLK_LO, BitHold);
               end
               PH_ACK_CLK_LO: begin
                  clk_q = 1'b0;
                  hop(PH_ACK_PAD, BitHold);
               end
               PH_ACK_PAD: begin
                  hop(PH_ACK_END, BitHold);
               end
               PH_ACK_END: begin
                  if (!r.dio_sample) ack_bad = 1'b1;
                  oe_q = 1'b1;
                  byte_pos++;
                  if (byte_pos < frame_len && byte_pos < FrameDepth) begin
                     load_frame_byte();
                  end else begin
                     clk_q = 1'b0;
                     dio_q = 1'b0;
                     hop(PH_STOP_B, EdgeHold);
                  end
               end
               PH_STOP_B: begin
                  clk_q = 1'b1;
                  hop(PH_STOP_C, EdgeHold);
               end
               PH_STOP_C: begin
                  dio_q = 1'b1;
                  hop(PH_FINISH, EdgeHold);
               end
               default: begin   // finish tick
                  seq_phase = PH_IDLE;
                  hold_left = 0;
                  finished  = 1'b1;
               end
            endcase
         end
         lv.clk_level     = clk_q;
         lv.dio_level     = dio_q;
         lv.dio_drive     = oe_q;
         lv.busy_res      = (seq_phase != PH_IDLE);
         lv.ack_error     = (seq_phase == PH_IDLE) ? ack_bad : 1'b0;
         lv.transfer_done = finished;
         expected_levels.push_back(lv);
      endfunction

      function void check_field(string name, logic want, logic got);
         if (got !== want) begin
            $error("%s: expected %0b, got %0b", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         responses++;
         if (expected_levels.size() == 0) begin
            $error("response with no request pending");
            mismatches++;
            return;
         end
         want = expected_levels.pop_front();
         check_field("clk_level",     want.clk_level,     got.clk_level);
         check_field("dio_level",     want.dio_level,     got.dio_level);
         check_field("dio_drive",     want.dio_drive,     got.dio_drive);
         check_field("busy_res",      want.busy_res,      got.busy_res);
         check_field("ack_error",     want.ack_error,     got.ack_error);
         check_field("transfer_done", want.transfer_done, got.transfer_done);
         if (got.transfer_done) begin
            done_seen++;
            if (got.ack_error) ack_errors_seen++;
         end
      endfunction

      function bit idle();
         return seq_phase == PH_IDLE;
      endfunction

      // Which acknowledge sample the next tick will take, if any.
      function ack_slot_type ack_slot();
         if (hold_left != 0) return SLOT_NONE;
         if (seq_phase == PH_ACK_SAMPLE) return SLOT_FIRST;
         if (seq_phase == PH_ACK_END) return SLOT_SECOND;
         return SLOT_NONE;
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // Clock, reset and DUT
   // ---------------------------------------------------------------------
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   request_type req_q       = '0;
   logic        rsp_ready   = 1'b0;
   logic        csr_wr_en   = 1'b0;
   logic [2:0]  csr_wr_data = 3'd0;

   logic req_ready;
   logic rsp_valid;
   logic rsp_clk_level;
   logic rsp_dio_level;
   logic rsp_dio_drive;
   logic rsp_busy_res;
   logic rsp_ack_error;
   logic rsp_transfer_done;

   wave_scoreboard sb;
   int unsigned    sent       = 0;
   int unsigned    burst_left = 0;

   always #5ns clock = ~clock;

   segment_display_serial_writer_top #(
      .DIGIT_SLOTS    (DigitSlots),
      .BIT_HOLD_TICKS (BitHold),
      .EDGE_HOLD_TICKS(EdgeHold)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_q.command),
      .req_value        (req_q.value),
      .req_char_slot0   (req_q.chars[0]),
      .req_char_slot1   (req_q.chars[1]),
      .req_char_slot2   (req_q.chars[2]),
      .req_char_slot3   (req_q.chars[3]),
      .req_char_slot4   (req_q.chars[4]),
      .req_char_slot5   (req_q.chars[5]),
      .req_dio_sample   (req_q.dio_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_clk_level    (rsp_clk_level),
      .rsp_dio_level    (rsp_dio_level),
      .rsp_dio_drive    (rsp_dio_drive),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_ack_error    (rsp_ack_error),
      .rsp_transfer_done(rsp_transfer_done),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offers one request and holds it until accepted. Requests go out in
   // bursts; a gap of idle cycles may open before a new burst.
   task automatic send_request(input request_type r);
      int unsigned pause;
      if (burst_left == 0) begin
         pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (pause > 0) begin
            req_valid <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         // now and then a long burst with no gaps at all
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_q     <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // predictor runs right at the accepting edge, so the next request
      // is built from up-to-date line state
      sb.note_request(r);
      sent++;
   endtask

   // A plain tick with random filler; the data line read back follows the
   // acknowledge plan in the two sample ticks and is random elsewhere.
   function automatic request_type tick_item(input ack_plan_type plan);
      request_type  r;
      ack_slot_type slot;
      r.command    = CMD_TICK;
      r.value      = 8'($urandom);
      for (int i = 0; i < 6; i++) r.chars[i] = 8'($urandom);
      r.dio_sample = 1'($urandom);
      slot = sb.ack_slot();
      if (plan != ACK_RANDOM) begin
         if (slot == SLOT_FIRST) r.dio_sample = (plan == ACK_MISS_LOW);
         else if (slot == SLOT_SECOND) r.dio_sample = (plan != ACK_MISS_HIGH);
      end
      return r;
   endfunction

   function automatic logic [5:0][7:0] row_of(input string s);
      logic [5:0][7:0] row;
      for (int i = 0; i < 6; i++) row[i] = s.getc(i);
      return row;
   endfunction

   // Mix of displayable characters (both cases) and arbitrary bytes.
   function automatic logic [5:0][7:0] random_row();
      string           charset;
      logic [5:0][7:0] row;
      charset = "0123456789AaBbCcDdEeFf-_HhIiJjLlOoPpSsTtUuVvYyZz !";
      for (int i = 0; i < 6; i++) begin
         if ($urandom_range(0, 1) == 0) row[i] = charset.getc($urandom_range(0, charset.len() - 1));
         else row[i] = 8'($urandom);
      end
      return row;
   endfunction

   // Sends one command, then ticks until the predictor is idle again.
   // noise_pct puts random command codes on busy ticks (all ignored).
   task automatic run_transfer(input logic [2:0] cmd, input logic [7:0] val,
                               input logic [5:0][7:0] row, input ack_plan_type plan,
                               input int unsigned noise_pct);
      request_type r;
      r         = tick_item(plan);
      r.command = cmd;
      r.value   = val;
      r.chars   = row;
      send_request(r);
      while (!sb.idle()) begin
         r = tick_item(plan);
         if ($urandom_range(0, 99) < noise_pct) r.command = 3'($urandom);
         send_request(r);
      end
   endtask

   // Register write, only once every response is back and the line is idle.
   task automatic write_digits(input logic [2:0] n);
      req_valid <= 1'b0;
      while (sb.expected_levels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= n;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      sb.digits_cfg  = n;
      burst_left     = 0;
   endtask

   // ---------------------------------------------------------------------
   // Response side: stall pattern of its own, plus one long hold-off that
   // lets the queue fill and backs up the request channel.
   // ---------------------------------------------------------------------
   initial begin : receiver
      rx_mode_type mode;
      int unsigned span;
      logic [31:0] pattern;
      bit          held;
      mode    = RX_OPEN;
      span    = 0;
      pattern = '0;
      held    = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && sb.responses >= 60) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         if (span == 0) begin
            mode    = rx_mode_type'($urandom_range(0, 2));
            span    = $urandom_range(20, 120);
            pattern = $urandom | 32'h1;
         end
         span--;
         case (mode)
            RX_OPEN: rsp_ready <= 1'b1;
            RX_PATTERN: begin
               rsp_ready <= pattern[0];
               pattern    = {pattern[0], pattern[31:1]};
            end
            default: rsp_ready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Pre-edge values are sampled, so no ordering race with the DUT.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_response(rsp_type'({rsp_clk_level, rsp_dio_level, rsp_dio_drive,
                                      rsp_busy_res, rsp_ack_error, rsp_transfer_done}));
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The list is kept short: no-op codes, saturation, both acknowledge faults,
      // commands arriving while busy, the flag holding while idle and a one-digit
      // print.
      run_transfer(CMD_SPARE6, 8'h12,  row_of("012345"), ACK_RANDOM,    0);  // no-op code
      run_transfer(CMD_SPARE7, 8'hED,  row_of("012345"), ACK_RANDOM,    0);
      run_transfer(CMD_BRIGHT, 8'd9,   row_of("      "), ACK_MISS_LOW, 25);  // saturates
      run_transfer(CMD_TICK,   8'hFF,  random_row(),     ACK_RANDOM,    0);  // flag holds
      run_transfer(CMD_SWITCH, 8'h80,  row_of("      "), ACK_MISS_HIGH, 0);  // nonzero is on
      write_digits(3'd1);
      run_transfer(CMD_PRINT,  8'd0,   row_of("    jE"), ACK_CLEAN,     5);

      // Drain, then wait for anything in flight.
      req_valid <= 1'b0;
      while (sb.expected_levels.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Run: %0d tick requests, %0d transfers started, %0d completed",
               sent, sb.transfers, sb.done_seen);
      $display("%0d ended with an ack error, one long receiver stall, %0d mismatches",
               sb.ack_errors_seen, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: well beyond the slowest legal run.
   initial begin : watchdog
      #40ms;
      $display("Timeout: responses still pending or stimulus stuck");
      $display("*** FAILED ***");
      $finish;
   end

endmodule
`default_nettype wire
